### src/pwm_frequency_duty_meter_top_defines.svh
// assertion macros for the pulse meter top level
// no dependencies; sampled on clock, disabled during reset
`ifndef PWM_FREQUENCY_DUTY_METER_TOP_DEFINES_SVH
`define PWM_FREQUENCY_DUTY_METER_TOP_DEFINES_SVH

// same-cycle implication
`define PFDM_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PFDM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/pfdm_pkg.sv
// shared constants and controller/datapath interface types for the pulse meter
// no dependencies
package pfdm_pkg;

   localparam int COUNTER_WIDTH_DEFAULT = 16;
   localparam int CLOCK_HZ_WIDTH        = 27;
   localparam logic [CLOCK_HZ_WIDTH-1:0] CLOCK_HZ_RESET = 27'd8000000;

   localparam int FREQ_WIDTH  = 26;
   localparam int DUTY_WIDTH  = 7;
   localparam int TICKS_WIDTH = 16;
   localparam logic [DUTY_WIDTH-1:0] PERCENT_SCALE = 7'd100;

   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 72;

   // controller to datapath
   typedef struct packed {
      logic step;           // input beat taken, update last level
      logic count_inc;
      logic count_clear;
      logic capture_rise;
      logic capture_fall;
      logic capture_end;    // second rising edge: latch period and high time
      logic start_freq;
      logic start_duty;
      logic load_result;
      logic oor;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rise;
      logic fall;
      logic cnt_max;
      logic period_zero;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

### src/pfdm_divider.sv
// restoring divider, one quotient bit per cycle
// standalone; no package dependencies
module pfdm_divider #(
   parameter int DW = 27,
   parameter int VW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CNTW = $clog2(DW + 1);
   localparam logic [CNTW-1:0] ITERATIONS = CNTW'(DW);
   localparam logic [CNTW-1:0] LAST_STEP  = CNTW'(1);

   logic            busy_ff;
   logic            done_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [DW-1:0]   q_ff;
   logic [VW-1:0]   rem_ff;
   logic [VW-1:0]   div_ff;

   logic [VW:0]     shifted;
   logic [VW:0]     diff;
   logic            ge;

   assign shifted = {rem_ff, q_ff[DW-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign ge      = shifted >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= ITERATIONS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - LAST_STEP;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[DW-2:0], ge};
         // remainder stays below the divisor, so the low bits suffice
         rem_ff <= ge ? diff[VW-1:0] : shifted[VW-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

### src/pfdm_datapath.sv
// edge detect, elapsed-tick counter, capture registers, divider and result register
// depends on pfdm_pkg and pfdm_divider
module pfdm_datapath #(
   parameter int COUNTER_WIDTH = pfdm_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pfdm_pkg::dp_cmd_type                  cmd,
   output pfdm_pkg::dp_status_type               status,
   input  logic                                  signal_level,
   input  logic [pfdm_pkg::CLOCK_HZ_WIDTH-1:0]   clock_hz,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic [pfdm_pkg::FREQ_WIDTH-1:0]       frequency_hz,
   output logic [pfdm_pkg::DUTY_WIDTH-1:0]       duty_percent,
   output logic [pfdm_pkg::TICKS_WIDTH-1:0]      high_ticks,
   output logic [pfdm_pkg::TICKS_WIDTH-1:0]      period_ticks,
   output logic                                  out_of_range
);
   import pfdm_pkg::*;

   localparam int CW = COUNTER_WIDTH;
   localparam int HW = CW + DUTY_WIDTH;
   localparam int DW = (CLOCK_HZ_WIDTH > HW) ? CLOCK_HZ_WIDTH : HW;
   localparam int XW = (CW > TICKS_WIDTH) ? CW : TICKS_WIDTH;

   logic                  last_level_ff;
   logic [CW-1:0]         cnt_ff;
   logic [CW-1:0]         rise_ff;
   logic [CW-1:0]         fall_ff;
   logic [CW-1:0]         period_ff;
   logic [CW-1:0]         high_ff;
   logic [HW-1:0]         high100_ff;
   logic [FREQ_WIDTH-1:0] freq_ff;

   logic                   rsp_valid_ff;
   logic [FREQ_WIDTH-1:0]  rsp_freq_ff;
   logic [DUTY_WIDTH-1:0]  rsp_duty_ff;
   logic [TICKS_WIDTH-1:0] rsp_high_ff;
   logic [TICKS_WIDTH-1:0] rsp_period_ff;
   logic                   rsp_oor_ff;

   logic [CW-1:0] high_diff;
   logic [XW-1:0] high_x;
   logic [XW-1:0] period_x;
   logic          div_start;
   logic [DW-1:0] div_dividend;
   logic          div_done;
   logic [DW-1:0] div_quotient;

   assign high_diff = fall_ff - rise_ff;
   assign high_x    = XW'(high_ff);
   assign period_x  = XW'(period_ff);

   assign status.rise        = signal_level & ~last_level_ff;
   assign status.fall        = ~signal_level & last_level_ff;
   assign status.cnt_max     = &cnt_ff;
   assign status.period_zero = (cnt_ff == rise_ff);
   assign status.div_done    = div_done;
   assign status.out_free    = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_level_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (cmd.step) begin
            last_level_ff <= signal_level;
         end
         if (cmd.count_clear || cmd.capture_end) begin
            cnt_ff <= '0;
         end else if (cmd.count_inc) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture_rise) begin
         rise_ff <= cnt_ff;
      end
      if (cmd.capture_fall) begin
         fall_ff <= cnt_ff;
      end
      if (cmd.capture_end) begin
         period_ff  <= cnt_ff - rise_ff;
         high_ff    <= high_diff;
         high100_ff <= HW'(high_diff) * HW'(PERCENT_SCALE);
      end
      if (cmd.start_duty) begin
         freq_ff <= div_quotient[FREQ_WIDTH-1:0];
      end
   end

   assign div_start    = cmd.start_freq | cmd.start_duty;
   assign div_dividend = cmd.start_freq ? DW'(clock_hz) : DW'(high100_ff);

   pfdm_divider #(
      .DW (DW),
      .VW (CW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (period_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_oor_ff <= cmd.oor;
         if (cmd.oor) begin
            rsp_freq_ff   <= '0;
            rsp_duty_ff   <= '0;
            rsp_high_ff   <= '0;
            rsp_period_ff <= '0;
         end else begin
            rsp_freq_ff   <= freq_ff;
            rsp_duty_ff   <= div_quotient[DUTY_WIDTH-1:0];
            rsp_high_ff   <= high_x[TICKS_WIDTH-1:0];
            rsp_period_ff <= period_x[TICKS_WIDTH-1:0];
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign frequency_hz = rsp_freq_ff;
   assign duty_percent = rsp_duty_ff;
   assign high_ticks   = rsp_high_ff;
   assign period_ticks = rsp_period_ff;
   assign out_of_range = rsp_oor_ff;

endmodule

### src/pfdm_ctrl.sv
// measurement sequencer: edge phases, wrap tracking and divide scheduling
// depends on pfdm_pkg
module pfdm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  pfdm_pkg::dp_status_type status,
   output pfdm_pkg::dp_cmd_type    cmd
);
   import pfdm_pkg::*;

   typedef enum logic [2:0] {
      ST_RISE1,
      ST_FALL,
      ST_RISE2,
      ST_REARM,
      ST_FREQ_START,
      ST_FREQ_WAIT,
      ST_DUTY_WAIT,
      ST_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      wrapped_ff, wrapped_in;
   logic      beat;

   always_comb begin
      req_tready = (state_ff == ST_RISE1) || (state_ff == ST_FALL) ||
                   (state_ff == ST_RISE2) || (state_ff == ST_REARM);
   end

   assign beat = req_tvalid & req_tready;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      wrapped_in = wrapped_ff;
      case (state_ff)
         ST_RISE1: begin
            if (beat) begin
               cmd.step      = 1'b1;
               cmd.count_inc = 1'b1;
               wrapped_in    = 1'b0;
               if (status.rise) begin
                  cmd.capture_rise = 1'b1;
                  state_in         = ST_FALL;
                  // wrap on the capture tick already counts
                  wrapped_in       = status.cnt_max;
               end
            end
         end
         ST_FALL: begin
            if (beat) begin
               cmd.step      = 1'b1;
               cmd.count_inc = 1'b1;
               if (status.fall) begin
                  cmd.capture_fall = 1'b1;
                  state_in         = ST_RISE2;
               end
               if (status.cnt_max) begin
                  wrapped_in = 1'b1;
               end
            end
         end
         ST_RISE2: begin
            if (beat) begin
               cmd.step = 1'b1;
               if (status.rise) begin
                  cmd.capture_end = 1'b1;
                  if (wrapped_ff || status.period_zero) begin
                     wrapped_in = 1'b1;
                     state_in   = ST_LOAD;
                  end else begin
                     state_in = ST_FREQ_START;
                  end
               end else begin
                  cmd.count_inc = 1'b1;
                  if (status.cnt_max) begin
                     wrapped_in = 1'b1;
                  end
               end
            end
         end
         ST_REARM: begin
            // this beat refreshes the last level and clears the tick counter
            if (beat) begin
               cmd.step        = 1'b1;
               cmd.count_clear = 1'b1;
               state_in        = ST_RISE1;
            end
         end
         ST_FREQ_START: begin
            cmd.start_freq = 1'b1;
            state_in       = ST_FREQ_WAIT;
         end
         ST_FREQ_WAIT: begin
            if (status.div_done) begin
               cmd.start_duty = 1'b1;
               state_in       = ST_DUTY_WAIT;
            end
         end
         ST_DUTY_WAIT: begin
            if (status.div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_result = 1'b1;
               cmd.oor         = wrapped_ff;
               state_in        = ST_REARM;
            end
         end
         default: begin
            state_in = ST_RISE1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RISE1;
         wrapped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wrapped_ff <= wrapped_in;
      end
   end

endmodule

### src/pwm_frequency_duty_meter_top.sv
// pulse frequency and duty meter: one level sample per req beat, one beat per cycle while
// measuring. the beat on the closing rising edge stalls req for the two divides on the
// shared restoring divider (DIV_WIDTH = max(27, COUNTER_WIDTH + 7)), frequency first and
// then duty, and for the load of the result, which waits until rsp is free;
// out-of-range results skip the divides and go to the load. synchronous active-high reset
// re-arms the measurement and sets clock_hz to 8000000; there is no clearing pass.
`include "pwm_frequency_duty_meter_top_defines.svh"

module pwm_frequency_duty_meter_top #(
   parameter int COUNTER_WIDTH = pfdm_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pfdm_pkg::CLOCK_HZ_WIDTH-1:0]  csr_data,    // clock_hz
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pfdm_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,   // [0] signal_level, rest zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [25:0] frequency_hz, [32:26] duty_percent, [48:33] high_ticks,
   // [64:49] period_ticks, [71:65] zero
   output logic [pfdm_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   output logic                                 rsp_tuser    // [0] out_of_range
);
   import pfdm_pkg::*;

   localparam int RSP_PAD_WIDTH =
      RSP_DATA_WIDTH - FREQ_WIDTH - DUTY_WIDTH - 2 * TICKS_WIDTH;

   logic [CLOCK_HZ_WIDTH-1:0] clock_hz_ff;
   dp_cmd_type                cmd;
   dp_status_type             status;
   logic [FREQ_WIDTH-1:0]     frequency_hz;
   logic [DUTY_WIDTH-1:0]     duty_percent;
   logic [TICKS_WIDTH-1:0]    high_ticks;
   logic [TICKS_WIDTH-1:0]    period_ticks;
   logic                      out_of_range;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_HZ_RESET;
      end else if (csr_valid && csr_ready) begin
         clock_hz_ff <= csr_data;
      end
   end

   pfdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pfdm_datapath #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .signal_level (req_tdata[0]),
      .clock_hz     (clock_hz_ff),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .frequency_hz (frequency_hz),
      .duty_percent (duty_percent),
      .high_ticks   (high_ticks),
      .period_ticks (period_ticks),
      .out_of_range (out_of_range)
   );

   assign rsp_tdata = {{RSP_PAD_WIDTH{1'b0}}, period_ticks, high_ticks, duty_percent,
                       frequency_hz};
   assign rsp_tuser = out_of_range;

   // out-of-range beats carry no measurement
   `PFDM_ASSERT_IMPLY(a_oor_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "oor beat has data")
   // the divider only finishes while input is stalled
   `PFDM_ASSERT_IMPLY(a_div_stall, status.div_done, !req_tready, "divide done while accepting")
   // a loaded result is offered on the next cycle
   `PFDM_ASSERT_NEXT(a_load_valid, cmd.load_result, rsp_tvalid, "loaded result not offered")
   // a new result only appears after a stall on the input side
   `PFDM_ASSERT_IMPLY(a_rsp_after_stall, $rose(rsp_tvalid), !$past(req_tready), "rsp without stall")

endmodule

### verif/tb_top.sv
// testbench for the pulse frequency and duty meter: level samples go in as req beats, an
// in-line predictor follows every accepted beat and each rsp beat is checked field by field
// depends on pfdm_pkg and pwm_frequency_duty_meter_top
module tb_top;
   import pfdm_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 7;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 100;
   localparam int CNT_W         = COUNTER_WIDTH_DEFAULT;

   typedef enum logic [1:0] {WAIT_RISE, WAIT_FALL, WAIT_CLOSE, REARM} meter_phase_type;

   typedef struct packed {
      logic [FREQ_WIDTH-1:0]  freq;
      logic [DUTY_WIDTH-1:0]  duty;
      logic [TICKS_WIDTH-1:0] high;
      logic [TICKS_WIDTH-1:0] period;
      logic                   oor;
   } meter_result_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CLOCK_HZ_WIDTH-1:0] csr_data;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tuser;

   // predictor state
   meter_phase_type           phase_q;
   logic                      wrapped_q;
   logic                      last_level_q;
   logic [CNT_W-1:0]          elapsed_q;
   logic [CNT_W-1:0]          rise_at_q;
   logic [CNT_W-1:0]          fall_at_q;
   logic [CLOCK_HZ_WIDTH-1:0] clock_hz_q;
   meter_result_type          pending_results[$];

   int                        mismatches = 0;
   int                        cycles = 0;
   int                        beats_sent = 0;
   int                        stall_left = 0;
   bit                        gaps_on;

   pwm_frequency_duty_meter_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_run();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return $urandom_range(1, 6);
      if (roll < 97) return $urandom_range(7, 40);
      return $urandom_range(41, 400);
   endfunction

   // advance the meter by one accepted sample, queue the measurement if one closes
   function automatic void step_meter(input logic lvl);
      logic             rise;
      logic             fall;
      logic [CNT_W-1:0] now;
      logic [CNT_W-1:0] high;
      logic [CNT_W-1:0] period;
      meter_result_type r;
      rise = lvl & ~last_level_q;
      fall = ~lvl & last_level_q;
      now = elapsed_q;
      last_level_q = lvl;
      if (phase_q == REARM) begin
         phase_q = WAIT_RISE;
         elapsed_q = '0;
         return;
      end
      case (phase_q)
         WAIT_RISE: begin
            wrapped_q = 1'b0;
            if (rise) begin
               rise_at_q = now;
               phase_q = WAIT_FALL;
            end
         end
         WAIT_FALL: begin
            if (fall) begin
               fall_at_q = now;
               phase_q = WAIT_CLOSE;
            end
         end
         default: begin
            if (rise) begin
               high = fall_at_q - rise_at_q;
               period = now - rise_at_q;
               r = '0;
               if (wrapped_q || period == 0) begin
                  r.oor = 1'b1;
               end else begin
                  r.freq = FREQ_WIDTH'(clock_hz_q / period);
                  r.duty = DUTY_WIDTH'((32'(high) * PERCENT_SCALE) / period);
                  r.high = high;
                  r.period = period;
               end
               pending_results.push_back(r);
               phase_q = REARM;
               elapsed_q = '0;
               return;
            end
         end
      endcase
      elapsed_q = now + 1'b1;
      // a wrap only matters once the first rising edge is in
      if (elapsed_q == 0 && phase_q != WAIT_RISE) wrapped_q = 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // rsp side: sample at the rising edge
   always @(posedge clock) begin
      meter_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("rsp beat with no measurement pending");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("frequency_hz", 32'(want.freq), 32'(rsp_tdata[25:0]));
            check_field("duty_percent", 32'(want.duty), 32'(rsp_tdata[32:26]));
            check_field("high_ticks", 32'(want.high), 32'(rsp_tdata[48:33]));
            check_field("period_ticks", 32'(want.period), 32'(rsp_tdata[64:49]));
            check_field("tdata padding", 32'd0, 32'(rsp_tdata[71:65]));
            check_field("out_of_range", 32'(want.oor), 32'(rsp_tuser));
         end
      end
   end

   // rsp backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (gaps_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("pwm_frequency_duty_meter_top: mismatch");
         $finish;
      end
   end

   // returns right after the beat is taken; the next call or settle() moves tvalid
   task automatic send_level(input logic lvl);
      int gap;
      gap = gaps_on ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_WIDTH-1){1'b0}}, lvl};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      step_meter(lvl);
   endtask

   task automatic send_run(input logic lvl, input int count);
      repeat (count) send_level(lvl);
   endtask

   // one low beat (the re-arm beat after a result), a pulse and the closing rising edge
   task automatic measure(input int high_len, input int low_len);
      send_run(1'b0, 1);
      send_run(1'b1, high_len);
      send_run(1'b0, low_len);
      send_run(1'b1, 1);
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_clock_hz(input logic [CLOCK_HZ_WIDTH-1:0] hz);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= hz;
      do @(posedge clock); while (!csr_ready);
      clock_hz_q = hz;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // high first sample after reset counts as a rising edge at zero
   task automatic test_reset_edge();
      send_run(1'b1, 1);
      send_run(1'b0, 1);
      send_run(1'b1, 1);
   endtask

   task automatic test_clock_extremes();
      logic [CLOCK_HZ_WIDTH-1:0] rates[4];
      rates = '{27'd100_000_000, 27'd1, 27'd0, {CLOCK_HZ_WIDTH{1'b1}}};
      foreach (rates[i]) begin
         write_clock_hz(rates[i]);
         measure(1, 1);
         measure(2, 3);
      end
   endtask

   task automatic test_duty_extremes();
      measure(1, 200);
      measure(200, 1);
      measure(3, 3);
   endtask

   task automatic random_burst(input int count);
      int goal;
      goal = beats_sent + count;
      while (beats_sent < goal) begin
         if ($urandom_range(0, 99) < 85) measure(pick_run(), pick_run());
         else repeat ($urandom_range(1, 10)) send_level(1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_random_trains();
      logic [CLOCK_HZ_WIDTH-1:0] rate;
      for (int p = 0; p < 7; p++) begin
         case (p)
            0: rate = CLOCK_HZ_RESET;
            1: rate = 27'd1;
            2: rate = 27'd100_000_000;
            3: rate = {CLOCK_HZ_WIDTH{1'b1}};
            4: rate = CLOCK_HZ_WIDTH'($urandom);
            default: rate = CLOCK_HZ_WIDTH'($urandom_range(1, 100_000_000));
         endcase
         write_clock_hz(rate);
         gaps_on = (p != 2);
         random_burst(110);
         // sender holds off until every pending result is out
         settle();
         random_burst(110);
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      clock        = 1'b0;
      reset        = 1'b1;
      csr_valid    = 1'b0;
      csr_data     = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      rsp_tready   = 1'b0;
      gaps_on      = 1'b1;
      phase_q      = WAIT_RISE;
      wrapped_q    = 1'b0;
      last_level_q = 1'b0;
      elapsed_q    = '0;
      rise_at_q    = '0;
      fall_at_q    = '0;
      clock_hz_q   = CLOCK_HZ_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_edge();
      test_clock_extremes();
      test_duty_extremes();
      test_random_trains();

      settle();
      if (mismatches == 0) begin
         $display("pwm_frequency_duty_meter_top: match");
      end else begin
         $display("pwm_frequency_duty_meter_top: mismatch");
      end
      $finish;
   end

endmodule
